// ----- src/wpp_pkg.sv -----
// shared types, constants and codes of the wave pcm parser
package wpp_pkg;

   localparam int MAX_CHANNELS = 8;
   // magnitude of a frame sum, plus sign
   localparam int SUM_W = 24 + $clog2(MAX_CHANNELS) + 1;
   // channel count and channel index width
   localparam int DIV_W = $clog2(MAX_CHANNELS + 1);
   localparam int CNT_W = $clog2(SUM_W);

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] FMT_PCM  = 16'd1;
   localparam logic [15:0] BITS_16  = 16'd16;
   localparam logic [15:0] BITS_24  = 16'd24;
   localparam logic [31:0] MIN_FMT_LEN = 32'd16;

   typedef enum logic [1:0] {
      KIND_SAMPLE  = 2'd0,
      KIND_FORMAT  = 2'd1,
      KIND_END_OK  = 2'd2,
      KIND_END_BAD = 2'd3
   } kind_type;

   typedef enum logic [6:0] {
      PH_RIFF  = 7'b000_0001,
      PH_RSIZE = 7'b000_0010,
      PH_WAVE  = 7'b000_0100,
      PH_HDR   = 7'b000_1000,
      PH_BODY  = 7'b001_0000,
      PH_PAD   = 7'b010_0000,
      PH_HALT  = 7'b100_0000
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_OUT1 = 4'b0100,
      ST_OUT2 = 4'b1000
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic sel_end;
   } cmd_type;

   typedef struct packed {
      logic ev_frame;
      logic ev_format;
      logic ev_end;
      logic end_pend;
      logic div_last;
   } status_type;

endpackage

// ----- src/wpp_req_if.sv -----
// input byte channel
interface wpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_final;

   modport source (output valid, output data_byte, output is_final, input ready);
   modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

// ----- src/wpp_rsp_if.sv -----
// result channel
interface wpp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [23:0] mono_sample;
   logic [31:0]        sample_rate;
   logic [15:0]        channel_count;
   logic [15:0]        sample_bits;

   modport source (output valid, output kind, output mono_sample, output sample_rate,
                   output channel_count, output sample_bits, input ready);
   modport sink   (input valid, input kind, input mono_sample, input sample_rate,
                   input channel_count, input sample_bits, output ready);
endinterface

// ----- src/wpp_ctrl.sv -----
// handshake sequencer: accept, divide, deliver results
module wpp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  wpp_pkg::status_type status,
   output wpp_pkg::cmd_type    cmd
);
   wpp_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_ready    = (state_ff == wpp_pkg::ST_IDLE);
      rsp_valid    = (state_ff == wpp_pkg::ST_OUT1) || (state_ff == wpp_pkg::ST_OUT2);
      cmd.accept   = req_ready && req_valid;
      cmd.div_step = (state_ff == wpp_pkg::ST_DIV);
      cmd.sel_end  = (state_ff == wpp_pkg::ST_OUT2);
      unique case (state_ff)
         wpp_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.ev_frame)       state_in = wpp_pkg::ST_DIV;
               else if (status.ev_format) state_in = wpp_pkg::ST_OUT1;
               else if (status.ev_end)    state_in = wpp_pkg::ST_OUT2;
            end
         end
         wpp_pkg::ST_DIV: begin
            if (status.div_last) state_in = wpp_pkg::ST_OUT1;
         end
         wpp_pkg::ST_OUT1: begin
            if (rsp_ready) state_in = status.end_pend ? wpp_pkg::ST_OUT2 : wpp_pkg::ST_IDLE;
         end
         wpp_pkg::ST_OUT2: begin
            if (rsp_ready) state_in = wpp_pkg::ST_IDLE;
         end
         default: state_in = wpp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= wpp_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule

// ----- src/wpp_dpath.sv -----
// parser state, frame accumulator, channel divider and result registers
module wpp_dpath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          data_byte,
   input  logic                is_final,
   input  wpp_pkg::cmd_type    cmd,
   output wpp_pkg::status_type status,
   output logic [1:0]          kind,
   output logic signed [23:0]  mono_sample,
   output logic [31:0]         sample_rate,
   output logic [15:0]         channel_count,
   output logic [15:0]         sample_bits
);
   localparam int SW = wpp_pkg::SUM_W;
   localparam int DW = wpp_pkg::DIV_W;
   localparam int CW = wpp_pkg::CNT_W;

   wpp_pkg::phase_type phase_ff, phase_in;
   logic [4:0]    pos_ff, pos_in;
   logic [31:0]   tag_ff, tag_in;
   logic [31:0]   remain_ff, remain_in;
   logic          pad_ff, pad_in;
   logic [15:0]   fcode_ff, fcode_in;
   logic [15:0]   nch_ff, nch_in;
   logic [31:0]   rate_ff, rate_in;
   logic [15:0]   bits_ff, bits_in;
   logic          fseen_ff, fseen_in;
   logic          ddone_ff, ddone_in;
   logic [23:0]   asm_ff, asm_in;
   logic [1:0]    bis_ff, bis_in;
   logic [DW-1:0] chidx_ff, chidx_in;
   logic [SW-1:0] fsum_ff, fsum_in;
   logic          err_ff, err_in;

   // result and divider registers
   wpp_pkg::kind_type first_kind_ff, end_kind_ff;
   logic [31:0]   orate_ff;
   logic [15:0]   onch_ff, obits_ff;
   logic          end_pend_ff;
   logic [SW-1:0] dq_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] dvs_ff;
   logic          neg_ff;
   logic [CW-1:0] cnt_ff;

   logic          ev_frame, ev_format, do_end, fmt_ok, is_fmt_b, is_data_b, end_fmt;
   logic [SW-1:0] frame_total, mag;
   logic [23:0]   asm_new, sample_v;
   logic [1:0]    bis_next;
   logic [1:0]    need;
   wpp_pkg::kind_type end_kind;

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; tag_in = tag_ff; remain_in = remain_ff;
      pad_in = pad_ff; fcode_in = fcode_ff; nch_in = nch_ff; rate_in = rate_ff;
      bits_in = bits_ff; fseen_in = fseen_ff; ddone_in = ddone_ff; asm_in = asm_ff;
      bis_in = bis_ff; chidx_in = chidx_ff; fsum_in = fsum_ff; err_in = err_ff;
      ev_frame = 1'b0; ev_format = 1'b0; do_end = 1'b0; fmt_ok = 1'b0; end_fmt = 1'b0;
      frame_total = '0; asm_new = '0; sample_v = '0; bis_next = '0;
      is_fmt_b  = (tag_ff == wpp_pkg::TAG_FMT) && !fseen_ff;
      is_data_b = (tag_ff == wpp_pkg::TAG_DATA) && fseen_ff && !ddone_ff;
      need      = (bits_ff == wpp_pkg::BITS_16) ? 2'd2 : 2'd3;

      unique case (phase_ff)
         wpp_pkg::PH_RIFF, wpp_pkg::PH_WAVE: begin
            tag_in = {tag_ff[23:0], data_byte};
            pos_in = pos_ff + 5'd1;
            if (pos_ff == 5'd3) begin
               if (tag_in != ((phase_ff == wpp_pkg::PH_RIFF) ? wpp_pkg::TAG_RIFF
                                                             : wpp_pkg::TAG_WAVE)) begin
                  err_in = 1'b1; phase_in = wpp_pkg::PH_HALT;
               end else if (phase_ff == wpp_pkg::PH_RIFF) begin
                  phase_in = wpp_pkg::PH_RSIZE; pos_in = '0; tag_in = '0;
               end else begin
                  phase_in = wpp_pkg::PH_HDR; pos_in = '0; tag_in = '0; remain_in = '0;
               end
            end
         end
         wpp_pkg::PH_RSIZE: begin
            pos_in = pos_ff + 5'd1;
            if (pos_ff == 5'd3) begin
               phase_in = wpp_pkg::PH_WAVE; pos_in = '0; tag_in = '0;
            end
         end
         wpp_pkg::PH_HDR: begin
            if (pos_ff < 5'd4) tag_in = {tag_ff[23:0], data_byte};
            else begin
               unique case (pos_ff[1:0])
                  2'd0: remain_in = remain_ff | {24'd0, data_byte};
                  2'd1: remain_in = remain_ff | {16'd0, data_byte, 8'd0};
                  2'd2: remain_in = remain_ff | {8'd0, data_byte, 16'd0};
                  default: remain_in = remain_ff | {data_byte, 24'd0};
               endcase
            end
            pos_in = pos_ff + 5'd1;
            if (pos_ff == 5'd7) begin
               // chunk header complete
               pad_in = remain_in[0];
               if (tag_in == wpp_pkg::TAG_FMT && !fseen_ff && remain_in < wpp_pkg::MIN_FMT_LEN)
               begin
                  err_in = 1'b1; phase_in = wpp_pkg::PH_HALT;
               end else if (tag_in == wpp_pkg::TAG_DATA && !fseen_ff) begin
                  err_in = 1'b1; phase_in = wpp_pkg::PH_HALT;
               end else begin
                  asm_in = '0; bis_in = '0; chidx_in = '0; fsum_in = '0; pos_in = '0;
                  if (remain_in == 32'd0) do_end = 1'b1;
                  else phase_in = wpp_pkg::PH_BODY;
               end
            end
         end
         wpp_pkg::PH_BODY: begin
            if (is_fmt_b) begin
               unique case (pos_ff)
                  5'd0:  fcode_in = {fcode_ff[15:8], data_byte};
                  5'd1:  fcode_in = {data_byte, fcode_ff[7:0]};
                  5'd2:  nch_in   = {nch_ff[15:8], data_byte};
                  5'd3:  nch_in   = {data_byte, nch_ff[7:0]};
                  5'd4:  rate_in  = {rate_ff[31:8], data_byte};
                  5'd5:  rate_in  = {rate_ff[31:16], data_byte, rate_ff[7:0]};
                  5'd6:  rate_in  = {rate_ff[31:24], data_byte, rate_ff[15:0]};
                  5'd7:  rate_in  = {data_byte, rate_ff[23:0]};
                  5'd14: bits_in  = {bits_ff[15:8], data_byte};
                  5'd15: bits_in  = {data_byte, bits_ff[7:0]};
                  default: ;
               endcase
            end else if (is_data_b) begin
               unique case (bis_ff)
                  2'd0: asm_new = asm_ff | {16'd0, data_byte};
                  2'd1: asm_new = asm_ff | {8'd0, data_byte, 8'd0};
                  default: asm_new = asm_ff | {data_byte, 16'd0};
               endcase
               bis_next = bis_ff + 2'd1;
               asm_in = asm_new; bis_in = bis_next;
               if (bis_next >= need) begin
                  sample_v = (need == 2'd2) ? {asm_new[15:0], 8'd0} : asm_new;
                  frame_total = fsum_ff + {{(SW-24){sample_v[23]}}, sample_v};
                  asm_in = '0; bis_in = '0;
                  fsum_in = frame_total;
                  chidx_in = chidx_ff + 1'b1;
                  if ({{(16-DW){1'b0}}, chidx_in} >= nch_ff && nch_ff != 16'd0) begin
                     ev_frame = 1'b1;
                     chidx_in = '0; fsum_in = '0;
                  end
               end
            end
            // position only matters up to the end of the fmt fields
            if (pos_ff != 5'd16) pos_in = pos_ff + 5'd1;
            remain_in = remain_ff - 32'd1;
            if (remain_in == 32'd0) do_end = 1'b1;
         end
         wpp_pkg::PH_PAD: begin
            phase_in = wpp_pkg::PH_HDR; pos_in = '0; tag_in = '0; remain_in = '0;
         end
         default: ;
      endcase

      if (do_end) begin
         fmt_ok = fcode_in == wpp_pkg::FMT_PCM && nch_in != 16'd0 &&
                  nch_in <= 16'(wpp_pkg::MAX_CHANNELS) && rate_in != 32'd0 && !rate_in[31] &&
                  (bits_in == wpp_pkg::BITS_16 || bits_in == wpp_pkg::BITS_24);
         end_fmt = (tag_in == wpp_pkg::TAG_FMT) && !fseen_in;
         if (end_fmt && !fmt_ok) begin
            err_in = 1'b1; phase_in = wpp_pkg::PH_HALT;
         end else begin
            if (end_fmt) begin
               fseen_in = 1'b1; ev_format = 1'b1;
            end else if (tag_in == wpp_pkg::TAG_DATA && fseen_in && !ddone_in) begin
               ddone_in = 1'b1; asm_in = '0; bis_in = '0; chidx_in = '0; fsum_in = '0;
            end
            if (pad_in) begin
               phase_in = wpp_pkg::PH_PAD; pos_in = '0;
            end else begin
               phase_in = wpp_pkg::PH_HDR; pos_in = '0; tag_in = '0; remain_in = '0;
            end
         end
      end

      end_kind = (!err_in && fseen_in && ddone_in) ? wpp_pkg::KIND_END_OK
                                                    : wpp_pkg::KIND_END_BAD;
   end

   assign mag = frame_total[SW-1] ? (~frame_total + 1'b1) : frame_total;

   always_ff @(posedge clock) begin
      if (reset || (cmd.accept && is_final)) begin
         phase_ff <= wpp_pkg::PH_RIFF; pos_ff <= '0; tag_ff <= '0; remain_ff <= '0;
         pad_ff <= 1'b0; fcode_ff <= '0; nch_ff <= '0; rate_ff <= '0; bits_ff <= '0;
         fseen_ff <= 1'b0; ddone_ff <= 1'b0; asm_ff <= '0; bis_ff <= '0;
         chidx_ff <= '0; fsum_ff <= '0; err_ff <= 1'b0;
      end else if (cmd.accept) begin
         phase_ff <= phase_in; pos_ff <= pos_in; tag_ff <= tag_in; remain_ff <= remain_in;
         pad_ff <= pad_in; fcode_ff <= fcode_in; nch_ff <= nch_in; rate_ff <= rate_in;
         bits_ff <= bits_in; fseen_ff <= fseen_in; ddone_ff <= ddone_in; asm_ff <= asm_in;
         bis_ff <= bis_in; chidx_ff <= chidx_in; fsum_ff <= fsum_in; err_ff <= err_in;
      end
   end

   // restoring divide of the frame sum magnitude by the channel count
   logic [DW:0] rshift;
   logic        ge;
   assign rshift = {rem_ff, dq_ff[SW-1]};
   assign ge     = rshift >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         end_pend_ff   <= is_final;
         end_kind_ff   <= end_kind;
         first_kind_ff <= ev_frame ? wpp_pkg::KIND_SAMPLE : wpp_pkg::KIND_FORMAT;
         orate_ff      <= rate_in;
         onch_ff       <= nch_in;
         obits_ff      <= bits_in;
         dq_ff         <= mag;
         neg_ff        <= frame_total[SW-1];
         rem_ff        <= '0;
         dvs_ff        <= nch_ff[DW-1:0];
         cnt_ff        <= '0;
      end else if (cmd.div_step) begin
         // remainder stays below the divisor, so it fits the divisor width
         rem_ff <= ge ? DW'(rshift - {1'b0, dvs_ff}) : rshift[DW-1:0];
         dq_ff  <= {dq_ff[SW-2:0], ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   logic [SW-1:0] qsigned;
   assign qsigned = neg_ff ? (~dq_ff + 1'b1) : dq_ff;

   always_comb begin
      status.ev_frame  = ev_frame;
      status.ev_format = ev_format;
      status.ev_end    = is_final;
      status.end_pend  = end_pend_ff;
      status.div_last  = (cnt_ff == CW'(SW - 1));
      kind          = cmd.sel_end ? end_kind_ff : first_kind_ff;
      mono_sample   = '0;
      sample_rate   = '0;
      channel_count = '0;
      sample_bits   = '0;
      if (!cmd.sel_end) begin
         if (first_kind_ff == wpp_pkg::KIND_SAMPLE) mono_sample = signed'(qsigned[23:0]);
         else begin
            sample_rate = orate_ff; channel_count = onch_ff; sample_bits = obits_ff;
         end
      end
   end
endmodule

// ----- src/wave_pcm_parser_mono_downmix.sv -----
// top level of the riff/wave pcm parser with mono downmix
// usage:
//  - req_port carries one file byte per item plus is_final on the last byte
//  - rsp_port carries results: kind 0 mono sample, 1 format accepted,
//    2 end success, 3 end failure; unused fields read zero
//  - one byte is taken at a time; ready is high only while the block is idle
//  - a byte that produces no result leaves the block idle for the next byte
//  - a byte that completes a frame runs the channel divider, one quotient bit
//    per cycle over the whole frame sum width for any channel count (the
//    width being set by the eight-channel maximum), then presents the sample
//  - a format or lone end report appears in the cycle after the byte is taken
//  - the final byte yields up to two results: a sample or format report first,
//    then the end report, after which the parser is back in its reset state
//  - when the receiver stalls, the result holds and no further byte is taken
//  - reset (synchronous, active high) returns to expecting the riff tag
module wave_pcm_parser_mono_downmix (
   input  logic      clock,
   input  logic      reset,
   wpp_req_if.sink   req_port,
   wpp_rsp_if.source rsp_port
);
   wpp_pkg::cmd_type    cmd;
   wpp_pkg::status_type status;

   // handshake sequencer
   wpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // parser, accumulator and divider
   wpp_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .data_byte     (req_port.data_byte),
      .is_final      (req_port.is_final),
      .cmd           (cmd),
      .status        (status),
      .kind          (rsp_port.kind),
      .mono_sample   (rsp_port.mono_sample),
      .sample_rate   (rsp_port.sample_rate),
      .channel_count (rsp_port.channel_count),
      .sample_bits   (rsp_port.sample_bits)
   );
endmodule
